### hw/rtl/ccs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the chat color code stripper
// Holds the transaction payload structs, character codes, the parser phase
// encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ccs_pkg;

   // Default capacity of the held byte store.
   localparam int HELD_DEPTH_DEF = 63;

   // Character codes recognized by the parser.
   localparam logic [7:0] CHAR_COLOR     = 8'h03;
   localparam logic [7:0] CHAR_ESC       = 8'h1B;
   localparam logic [7:0] CHAR_BOLD      = 8'h02;
   localparam logic [7:0] CHAR_UNDERLINE = 8'h1F;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_M         = 8'h6D;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_ONE       = 8'h31;
   localparam logic [7:0] CHAR_SIX       = 8'h36;
   localparam logic [7:0] CHAR_NINE      = 8'h39;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       line_end;
      logic       held_overflow;
   } rsp_type;

   // Parser phase, one-hot.
   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_CC    = 7'b0000010,
      PH_FG1   = 7'b0000100,
      PH_FG2   = 7'b0001000,
      PH_COMMA = 7'b0010000,
      PH_BG1   = 7'b0100000,
      PH_ESC   = 7'b1000000
   } phase_type;

   // Controller state, one-hot.
   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_READ = 3'b010,
      ST_SEND = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic accept;      // request transaction taken this cycle
      logic flush_read;  // read the held store at the flush index
      logic flush_send;  // load the read byte into the response register
   } cmd_type;

   typedef struct packed {
      logic out_free;      // response register can take a new transaction
      logic flush_needed;  // current request ends a line with held bytes
      logic flush_last;    // flush index points at the final held byte
   } status_type;

endpackage
`default_nettype wire

### hw/rtl/ccs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_ctrl: sequencing controller
// Gates the request handshake and steps the datapath through the flush of
// held bytes at the end of a line.
// ----------------------------------------------------------------------------
module ccs_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  ccs_pkg::status_type  status,
   output ccs_pkg::cmd_type     cmd
);

   ccs_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      unique case (state_ff)
         ccs_pkg::ST_RUN: begin
            req_ready  = status.out_free;
            cmd.accept = req_valid && status.out_free;
            if (cmd.accept && status.flush_needed) begin
               state_in = ccs_pkg::ST_READ;
            end
         end
         ccs_pkg::ST_READ: begin
            cmd.flush_read = 1'b1;
            state_in       = ccs_pkg::ST_SEND;
         end
         ccs_pkg::ST_SEND: begin
            if (status.out_free) begin
               cmd.flush_send = 1'b1;
               state_in = status.flush_last ? ccs_pkg::ST_RUN : ccs_pkg::ST_READ;
            end
         end
         default: begin
            state_in = ccs_pkg::ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccs_pkg::ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/ccs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccs_datapath: parser, held byte store and response register
// Classifies each byte, keeps bytes seen inside an open escape sequence and
// presents one response transaction at a time.
// ----------------------------------------------------------------------------
module ccs_datapath #(
   parameter int HELD_DEPTH = ccs_pkg::HELD_DEPTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  ccs_pkg::req_type     req_data,
   input  ccs_pkg::cmd_type     cmd,
   output ccs_pkg::status_type  status,
   output ccs_pkg::rsp_type     rsp_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  wire                  csr_wr_en,
   input  wire                  csr_wr_data
);

   localparam int CW = $clog2(HELD_DEPTH + 1);
   localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

   logic [7:0] held_mem [HELD_DEPTH];

   logic                 strip_ff;
   logic                 escape_wait_ff, escape_wait_in;
   ccs_pkg::phase_type   phase_ff, phase_in;
   logic                 fdl_ff, fdl_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [CW-1:0]        flush_idx_ff, flush_idx_in;
   logic [7:0]           rd_data_ff;
   ccs_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [7:0] c;
   logic       is_digit, is_low_digit, is_0_to_6;
   logic       consumed, kept, ew_set, kept_out, hold_wr;
   logic       flush_needed;
   ccs_pkg::phase_type filt_phase;
   logic       filt_fdl;

   assign c            = req_data.data_byte;
   assign is_digit     = (c >= ccs_pkg::CHAR_ZERO) && (c <= ccs_pkg::CHAR_NINE);
   assign is_low_digit = (c == ccs_pkg::CHAR_ZERO) || (c == ccs_pkg::CHAR_ONE);
   assign is_0_to_6    = (c >= ccs_pkg::CHAR_ZERO) && (c <= ccs_pkg::CHAR_SIX);

   // Color code and escape parser for one byte.
   always_comb begin
      filt_phase = ccs_pkg::PH_IDLE;
      filt_fdl   = fdl_ff;
      consumed   = 1'b0;
      ew_set     = 1'b0;
      kept       = 1'b0;
      unique case (phase_ff)
         ccs_pkg::PH_CC: begin
            if (is_digit) begin
               filt_fdl   = is_low_digit;
               filt_phase = ccs_pkg::PH_FG1;
               consumed   = 1'b1;
            end
         end
         ccs_pkg::PH_FG1: begin
            if (is_0_to_6 && fdl_ff) begin
               filt_phase = ccs_pkg::PH_FG2;
               consumed   = 1'b1;
            end else if (c == ccs_pkg::CHAR_COMMA) begin
               filt_phase = ccs_pkg::PH_COMMA;
               consumed   = 1'b1;
            end
         end
         ccs_pkg::PH_FG2: begin
            if (c == ccs_pkg::CHAR_COMMA) begin
               filt_phase = ccs_pkg::PH_COMMA;
               consumed   = 1'b1;
            end
         end
         ccs_pkg::PH_COMMA: begin
            if (is_digit) begin
               filt_fdl   = is_low_digit;
               filt_phase = ccs_pkg::PH_BG1;
               consumed   = 1'b1;
            end
         end
         ccs_pkg::PH_BG1: begin
            if (is_0_to_6 && fdl_ff) begin
               consumed = 1'b1;
            end
         end
         ccs_pkg::PH_ESC: begin
            if (c == ccs_pkg::CHAR_LBRACKET) begin
               ew_set   = 1'b1;
               consumed = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // A byte that does not continue a code starts fresh.
      if (!consumed) begin
         if (c == ccs_pkg::CHAR_COLOR) begin
            filt_phase = ccs_pkg::PH_CC;
         end else if (c == ccs_pkg::CHAR_ESC) begin
            filt_phase = ccs_pkg::PH_ESC;
         end else if (!(strip_ff && (c == ccs_pkg::CHAR_BOLD ||
                                     c == ccs_pkg::CHAR_UNDERLINE))) begin
            kept = 1'b1;
         end
      end
   end

   // Next state for an accepted request.
   always_comb begin
      escape_wait_in      = escape_wait_ff;
      phase_in            = phase_ff;
      fdl_in              = fdl_ff;
      count_in            = count_ff;
      ovf_in              = ovf_ff;
      kept_out            = 1'b0;
      hold_wr             = 1'b0;
      flush_needed        = 1'b0;
      if (escape_wait_ff && c == ccs_pkg::CHAR_M) begin
         escape_wait_in = 1'b0;
         phase_in       = ccs_pkg::PH_IDLE;
         fdl_in         = 1'b0;
         count_in       = '0;
         ovf_in         = 1'b0;
      end else begin
         phase_in       = filt_phase;
         fdl_in         = filt_fdl;
         escape_wait_in = escape_wait_ff | ew_set;
         if (kept && escape_wait_in) begin
            if (count_ff < CW'(HELD_DEPTH)) begin
               hold_wr  = 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end else begin
            kept_out = kept;
         end
      end
      if (req_data.last_byte) begin
         flush_needed   = escape_wait_in && (count_in != '0);
         escape_wait_in = 1'b0;
         phase_in       = ccs_pkg::PH_IDLE;
         fdl_in         = 1'b0;
         if (!flush_needed) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   assign status = '{out_free:     !rsp_valid_ff || rsp_ready,
                     flush_needed: flush_needed,
                     flush_last:   (flush_idx_ff == (count_ff - 1'b1))};

   // Response register and flush index.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      flush_idx_in = flush_idx_ff;
      if (cmd.accept && (kept_out || (req_data.last_byte && !status.flush_needed))) begin
         rsp_in.out_byte      = kept_out ? c : 8'h00;
         rsp_in.byte_valid    = kept_out;
         rsp_in.line_end      = req_data.last_byte;
         rsp_in.held_overflow = req_data.last_byte && !kept_out && ovf_in;
         rsp_valid_in         = 1'b1;
      end
      if (cmd.flush_send) begin
         rsp_in.out_byte      = rd_data_ff;
         rsp_in.byte_valid    = 1'b1;
         rsp_in.line_end      = status.flush_last;
         rsp_in.held_overflow = ovf_ff;
         rsp_valid_in         = 1'b1;
         flush_idx_in         = status.flush_last ? '0 : flush_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff       <= 1'b1;
         escape_wait_ff <= 1'b0;
         phase_ff       <= ccs_pkg::PH_IDLE;
         fdl_ff         <= 1'b0;
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         flush_idx_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            strip_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            escape_wait_ff <= escape_wait_in;
            phase_ff       <= phase_in;
            fdl_ff         <= fdl_in;
            count_ff       <= count_in;
            ovf_ff         <= ovf_in;
         end else if (cmd.flush_send && status.flush_last) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
         flush_idx_ff <= flush_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Held byte store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.accept && hold_wr) begin
         held_mem[count_ff[AW-1:0]] <= c;
      end
      if (cmd.flush_read) begin
         rd_data_ff <= held_mem[flush_idx_ff[AW-1:0]];
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### hw/rtl/chat_color_code_stripper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chat_color_code_stripper: removes color and escape codes from a text line
// Byte-wide filter with a held byte store for unterminated escape sequences.
// ----------------------------------------------------------------------------
// The block takes one byte of a text line per request transaction and
// returns the bytes that survive filtering as response transactions. Color
// codes (0x03 with up to two foreground and two background digits), ESC and
// ESC-[ ... m sequences are removed, and bold and underline control bytes
// are removed while the csr bit is set (its reset value). Bytes after an
// ESC-[ are held, already filtered, in an internal store of HELD_DEPTH
// entries; an 'm' discards them, and if the line ends first they are sent
// after the last byte. Bytes that do not fit are dropped and the responses
// of that flush carry held_overflow. Every line ends with exactly one
// response that has line_end set; a line with nothing to send yields one
// response with byte_valid clear. Throughput is one byte per clock while
// the response side keeps up; the response register lets a new request be
// taken in the same cycle the previous response is taken. A line end that
// flushes held bytes occupies the block while each held byte in turn goes
// through the registered read of the store before it is loaded into the
// response register; no request is taken during the flush. The
// csr bit may be written only while no line is in progress in the block.
// ----------------------------------------------------------------------------
module chat_color_code_stripper #(
   parameter int HELD_DEPTH = ccs_pkg::HELD_DEPTH_DEF
) (
   input  wire                clock,
   input  wire                reset,
   // Request channel: one text byte per transaction.
   input  wire                req_valid,
   output logic               req_ready,
   input  ccs_pkg::req_type   req_data,
   // Response channel: one kept byte or line end marker per transaction.
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output ccs_pkg::rsp_type   rsp_data,
   // Configuration: strip_bold_underline.
   input  wire                csr_wr_en,
   input  wire                csr_wr_data
);

   ccs_pkg::cmd_type    cmd;
   ccs_pkg::status_type status;

   // The controller owns the handshake and the flush sequence.
   ccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the parser state, the held store and the response.
   ccs_datapath #(
      .HELD_DEPTH (HELD_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for chat_color_code_stripper
// Sends text lines byte by byte and predicts every response transaction.
// ----------------------------------------------------------------------------
// The bench keeps its own model of the stripper: the parser phase, the
// pending ESC-[ wait, the held bytes and the overflow flag. Each request
// transaction that the block accepts is run through that model, and the
// responses it should cause are queued. Each response that the block hands
// over is checked field by field against the oldest queued one.
//
// The run starts with a short directed list of bytes. A few rows carry an
// expected response typed in by hand. The rest of the list and all of the
// random lines are checked against the model. The random part runs in
// phases with different idle patterns and settings of the bold/underline
// bit. One phase opens with a long receiver hold-off so that the block
// fills up and stalls its request side. The same phase sends lines long
// enough to overflow the held store. Between phases the sender waits until
// every expected response has arrived before the csr bit is rewritten.
// ----------------------------------------------------------------------------
module testbench;

   // Cycles without any transaction before the run is declared hung.
   localparam int QUIET_LIMIT = 3000;
   // Length of the forced receiver hold-off.
   localparam int LONG_HOLD = 200;
   // Cycles allowed after the last response for stray traffic to show up.
   localparam int SETTLE = 20;
   // Random bytes per phase (four phases).
   localparam int PHASE_ITEMS = 12;

   typedef struct {
      ccs_pkg::req_type req;
      bit               lit;
      ccs_pkg::rsp_type want;
   } step_row_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ccs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ccs_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic             csr_wr_data = 1'b0;

   // Bench-side copy of the block state.
   bit                 strip_bu = 1'b1;
   bit                 esc_pending = 1'b0;
   ccs_pkg::phase_type parse_state = ccs_pkg::PH_IDLE;
   bit                 first_low = 1'b0;
   logic [7:0]         held_copy [0:ccs_pkg::HELD_DEPTH_DEF-1];
   int                 held_cnt = 0;
   bit                 held_lost = 1'b0;

   ccs_pkg::rsp_type stripped_now[$];
   ccs_pkg::rsp_type stripped_due[$];
   step_row_type     directed_rows[$];
   ccs_pkg::req_type line_bytes[$];

   int errors = 0;
   int sender_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int quiet_cycles = 0;

   chat_color_code_stripper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Runs one byte through the color code and escape parser. Returns 1 if
   // the byte survives; held-store handling is done by the caller.
   function automatic bit parse_keeps(input logic [7:0] c);
      bit is_dig;
      bit low_dig;
      is_dig = (c >= ccs_pkg::CHAR_ZERO) && (c <= ccs_pkg::CHAR_NINE);
      low_dig = (c >= ccs_pkg::CHAR_ZERO) && (c <= ccs_pkg::CHAR_SIX);
      case (parse_state)
         ccs_pkg::PH_CC: begin
            if (is_dig) begin
               first_low = (c == ccs_pkg::CHAR_ZERO) || (c == ccs_pkg::CHAR_ONE);
               parse_state = ccs_pkg::PH_FG1;
               return 1'b0;
            end
         end
         ccs_pkg::PH_FG1: begin
            if (low_dig && first_low) begin
               parse_state = ccs_pkg::PH_FG2;
               return 1'b0;
            end
            if (c == ccs_pkg::CHAR_COMMA) begin
               parse_state = ccs_pkg::PH_COMMA;
               return 1'b0;
            end
         end
         ccs_pkg::PH_FG2: begin
            if (c == ccs_pkg::CHAR_COMMA) begin
               parse_state = ccs_pkg::PH_COMMA;
               return 1'b0;
            end
         end
         ccs_pkg::PH_COMMA: begin
            if (is_dig) begin
               first_low = (c == ccs_pkg::CHAR_ZERO) || (c == ccs_pkg::CHAR_ONE);
               parse_state = ccs_pkg::PH_BG1;
               return 1'b0;
            end
         end
         ccs_pkg::PH_BG1: begin
            if (low_dig && first_low) begin
               parse_state = ccs_pkg::PH_IDLE;
               return 1'b0;
            end
         end
         ccs_pkg::PH_ESC: begin
            if (c == ccs_pkg::CHAR_LBRACKET) begin
               esc_pending = 1'b1;
               parse_state = ccs_pkg::PH_IDLE;
               return 1'b0;
            end
         end
         default: ;
      endcase
      // Any byte that did not continue a code starts over as a fresh byte.
      parse_state = ccs_pkg::PH_IDLE;
      if (c == ccs_pkg::CHAR_COLOR) begin
         parse_state = ccs_pkg::PH_CC;
         return 1'b0;
      end
      if (c == ccs_pkg::CHAR_ESC) begin
         parse_state = ccs_pkg::PH_ESC;
         return 1'b0;
      end
      if ((c == ccs_pkg::CHAR_BOLD || c == ccs_pkg::CHAR_UNDERLINE) && strip_bu)
         return 1'b0;
      return 1'b1;
   endfunction

   // Computes the responses caused by one request transaction into
   // stripped_now and advances the bench-side state.
   function automatic void strip_codes(input ccs_pkg::req_type r);
      bit               kept;
      ccs_pkg::rsp_type tail;
      kept = 1'b0;
      stripped_now.delete();
      if (esc_pending && r.data_byte == ccs_pkg::CHAR_M) begin
         // The closing 'm' throws away everything held since ESC-[.
         esc_pending = 1'b0;
         parse_state = ccs_pkg::PH_IDLE;
         first_low = 1'b0;
         held_cnt = 0;
         held_lost = 1'b0;
      end else begin
         kept = parse_keeps(r.data_byte);
         if (kept && esc_pending) begin
            if (held_cnt < ccs_pkg::HELD_DEPTH_DEF) begin
               held_copy[held_cnt] = r.data_byte;
               held_cnt++;
            end else begin
               held_lost = 1'b1;
            end
            kept = 1'b0;
         end
      end
      if (kept)
         stripped_now.push_back('{r.data_byte, 1'b1, 1'b0, 1'b0});
      if (r.last_byte) begin
         if (esc_pending) begin
            for (int i = 0; i < held_cnt; i++)
               stripped_now.push_back('{held_copy[i], 1'b1, 1'b0, held_lost});
         end
         // Every line closes with exactly one line_end response, empty or not.
         if (stripped_now.size() == 0) begin
            stripped_now.push_back('{8'h00, 1'b0, 1'b1, held_lost});
         end else begin
            tail = stripped_now.pop_back();
            tail.line_end = 1'b1;
            stripped_now.push_back(tail);
         end
         esc_pending = 1'b0;
         parse_state = ccs_pkg::PH_IDLE;
         first_low = 1'b0;
         held_cnt = 0;
         held_lost = 1'b0;
      end
   endfunction

   // Offers one byte, waits for the handshake and queues its responses.
   // Valid stays high into the next byte unless a sender gap is drawn.
   task automatic send_item(input ccs_pkg::req_type r, input bit lit,
                            input ccs_pkg::rsp_type want);
      int gap_cnt;
      gap_cnt = 0;
      while (gap_cnt < 40 && $urandom_range(0, 99) < sender_pct)
         gap_cnt++;
      if (gap_cnt > 0) begin
         req_valid <= 1'b0;
         repeat (gap_cnt) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      strip_codes(r);
      if (lit) begin
         stripped_due.push_back(want);
      end else begin
         foreach (stripped_now[i])
            stripped_due.push_back(stripped_now[i]);
      end
   endtask

   task automatic add_row(input int c, input bit last);
      step_row_type s;
      s.req = '{c[7:0], last};
      s.lit = 1'b0;
      s.want = '0;
      directed_rows.push_back(s);
   endtask

   task automatic add_lit(input int c, input bit last, input int ob, input bit bv,
                          input bit le);
      step_row_type s;
      s.req = '{c[7:0], last};
      s.lit = 1'b1;
      s.want = '{ob[7:0], bv, le, 1'b0};
      directed_rows.push_back(s);
   endtask

   task automatic push_byte(input int c);
      line_bytes.push_back('{c[7:0], 1'b0});
   endtask

   task automatic send_line();
      ccs_pkg::req_type tail;
      tail = line_bytes.pop_back();
      tail.last_byte = 1'b1;
      line_bytes.push_back(tail);
      foreach (line_bytes[i])
         send_item(line_bytes[i], 1'b0, '0);
   endtask

   // Builds one random line out of plain text, color codes, escape
   // sequences (closed and open), bold/underline bytes and raw noise.
   task automatic build_line();
      int kind;
      line_bytes.delete();
      repeat ($urandom_range(1, 10)) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            push_byte($urandom_range(8'h20, 8'h7E));
         end else if (kind < 45) begin
            push_byte(ccs_pkg::CHAR_COLOR);
            if ($urandom_range(0, 9) != 0) begin
               push_byte(ccs_pkg::CHAR_ZERO + $urandom_range(0, 9));
               if ($urandom_range(0, 1))
                  push_byte(ccs_pkg::CHAR_ZERO + $urandom_range(0, 9));
               if ($urandom_range(0, 1)) begin
                  push_byte(ccs_pkg::CHAR_COMMA);
                  if ($urandom_range(0, 3) != 0)
                     push_byte(ccs_pkg::CHAR_ZERO + $urandom_range(0, 9));
                  if ($urandom_range(0, 1))
                     push_byte(ccs_pkg::CHAR_ZERO + $urandom_range(0, 9));
               end
            end
         end else if (kind < 57) begin
            push_byte(ccs_pkg::CHAR_ESC);
            if ($urandom_range(0, 4) != 0) begin
               push_byte(ccs_pkg::CHAR_LBRACKET);
               repeat ($urandom_range(0, 5))
                  push_byte($urandom_range(0, 1) ?
                            ccs_pkg::CHAR_ZERO + $urandom_range(0, 9) :
                            $urandom_range(8'h20, 8'h7E));
               if ($urandom_range(0, 3) != 0)
                  push_byte(ccs_pkg::CHAR_M);
            end else begin
               push_byte($urandom_range(0, 255));
            end
         end else if (kind < 65) begin
            push_byte($urandom_range(0, 1) ? ccs_pkg::CHAR_BOLD : ccs_pkg::CHAR_UNDERLINE);
         end else if (kind < 85) begin
            push_byte($urandom_range(0, 255));
         end else begin
            case ($urandom_range(0, 4))
               0: push_byte(ccs_pkg::CHAR_COMMA);
               1: push_byte(ccs_pkg::CHAR_M);
               2: push_byte(ccs_pkg::CHAR_LBRACKET);
               3: push_byte(ccs_pkg::CHAR_SIX);
               default: push_byte(ccs_pkg::CHAR_NINE);
            endcase
         end
      end
   endtask

   // An open ESC-[ followed by more bytes than the held store takes. When
   // closed, the 'm' has to clear the overflow before the line ends.
   task automatic send_overflow_line(input bit closed);
      line_bytes.delete();
      push_byte(ccs_pkg::CHAR_ESC);
      push_byte(ccs_pkg::CHAR_LBRACKET);
      repeat ($urandom_range(ccs_pkg::HELD_DEPTH_DEF - 3, ccs_pkg::HELD_DEPTH_DEF + 7))
         push_byte($urandom_range("a", "l"));
      if (closed) begin
         push_byte(ccs_pkg::CHAR_M);
         push_byte("x");
      end
      send_line();
   endtask

   task automatic run_lines(input int target);
      int sent;
      sent = 0;
      while (sent < target) begin
         build_line();
         sent += line_bytes.size();
         send_line();
      end
   endtask

   // Sender goes quiet until every expected response has been taken, then
   // waits out the SETTLE period so that nothing is still in flight.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (stripped_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_strip(input bit v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      strip_bu = v;
   endtask

   // Response side: checks each accepted transaction and draws rsp_ready.
   // A hold-off request from the stimulus forces a long stretch of stalls.
   initial begin : rsp_side
      ccs_pkg::rsp_type want;
      int               hold_left;
      int               holds_served;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (stripped_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual %p",
                        $time, rsp_data);
            end else begin
               want = stripped_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.line_end !== want.line_end ||
                   rsp_data.held_overflow !== want.held_overflow) begin
                  errors++;
                  $display("%0t: response mismatch, expected %p, actual %p",
                           $time, want, rsp_data);
               end
            end
         end
         if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Watchdog: ends the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the bold/underline bit at its reset value.
      // Extremes of the byte range, one with the line end set.
      add_lit("A", 1'b0, "A", 1'b1, 1'b0);
      add_lit(8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
      add_lit(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1);
      // A line whose only byte is removed yields a bare line_end marker.
      add_lit(ccs_pkg::CHAR_COLOR, 1'b1, 8'h00, 1'b0, 1'b1);
      // Full color code with two-digit foreground and background.
      add_row(ccs_pkg::CHAR_COLOR, 1'b0);
      add_row(ccs_pkg::CHAR_ONE, 1'b0);
      add_row("5", 1'b0);
      add_row(ccs_pkg::CHAR_COMMA, 1'b0);
      add_row(ccs_pkg::CHAR_ZERO, 1'b0);
      add_row("3", 1'b0);
      add_row("x", 1'b0);
      // A second digit after a high first digit is kept as text.
      add_row(ccs_pkg::CHAR_COLOR, 1'b0);
      add_row(ccs_pkg::CHAR_NINE, 1'b0);
      add_row("5", 1'b0);
      // A comma is eaten even with no background digit after it.
      add_row(ccs_pkg::CHAR_COLOR, 1'b0);
      add_row("3", 1'b0);
      add_row(ccs_pkg::CHAR_COMMA, 1'b0);
      add_row(ccs_pkg::CHAR_BOLD, 1'b0);
      add_row(ccs_pkg::CHAR_UNDERLINE, 1'b1);
      // Lone ESC, then a nested ESC-[ inside a held stretch closed by 'm'.
      add_row(ccs_pkg::CHAR_ESC, 1'b0);
      add_row("q", 1'b0);
      add_row(ccs_pkg::CHAR_ESC, 1'b0);
      add_row(ccs_pkg::CHAR_LBRACKET, 1'b0);
      add_row("a", 1'b0);
      add_row(ccs_pkg::CHAR_ESC, 1'b0);
      add_row(ccs_pkg::CHAR_LBRACKET, 1'b0);
      add_row(ccs_pkg::CHAR_M, 1'b0);
      // An open ESC-[ at line end flushes the held byte.
      add_row(ccs_pkg::CHAR_ESC, 1'b0);
      add_row(ccs_pkg::CHAR_LBRACKET, 1'b0);
      add_row("z", 1'b1);
      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].lit, directed_rows[i].want);

      // No idling; the receiver opens with a long hold-off while the sender
      // keeps offering, then the held store is overrun.
      write_strip(1'b0);
      sender_pct = 0;
      stall_pct = 0;
      holds_asked <= holds_asked + 1;
      send_overflow_line(1'b0);
      send_overflow_line(1'b1);
      run_lines(PHASE_ITEMS);

      write_strip(1'b1);
      sender_pct = 74;
      stall_pct = 0;
      run_lines(PHASE_ITEMS);

      write_strip(1'b0);
      sender_pct = 0;
      stall_pct = 74;
      run_lines(PHASE_ITEMS);

      write_strip(1'b1);
      sender_pct = 16;
      stall_pct = 16;
      run_lines(PHASE_ITEMS);

      wait_drained();
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
